/* sv/ap_pkg.sv */
// Package with the shared types and the division step of the alpha unpremultiply block.
`default_nettype none
package ap_pkg;

   localparam int unsigned ChanW  = 8;
   localparam int unsigned ColorN = 3;
   localparam int unsigned QuotN  = 8;
   localparam logic [ChanW-1:0] ChanMax = 8'd255;

   typedef struct packed {
      logic [ChanW-1:0] rem;
      logic [ChanW-1:0] low;
      logic [ChanW-1:0] quo;
      logic             ovf;
   } ap_chan_type;

   typedef struct packed {
      ap_chan_type [ColorN-1:0] chan;
      logic [ChanW-1:0]         alpha;
      logic                     frame_end;
   } ap_cell_type;

   // One restoring division step: brings down the next dividend bit and
   // subtracts the divisor when it fits, producing one quotient bit.
   function automatic ap_chan_type ap_div_step(input ap_chan_type c,
                                               input logic [ChanW-1:0] a);
      ap_chan_type   r;
      logic [ChanW:0] t;
      t = {c.rem, c.low[ChanW-1]};
      r = c;
      r.low = {c.low[ChanW-2:0], 1'b0};
      if (t >= {1'b0, a}) begin
         r.rem = ChanW'(t - {1'b0, a});
         r.quo = {c.quo[ChanW-2:0], 1'b1};
      end else begin
         r.rem = t[ChanW-1:0];
         r.quo = {c.quo[ChanW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/alpha_unpremultiply_top.sv */
// Top level of the alpha unpremultiply block: entry stage, chain of division cells, output select.
//
//   Channel  Ports     Direction  Content
//   request  req_*     in         premultiplied pixel and end-of-frame mark
//   response rsp_*     out        straight-alpha pixel and end-of-frame mark
//
// One item enters per cycle while the output is not stalled; each item is registered in the entry
// stage and then in one cell per quotient bit before it leaves.
// Each stage holds its item until the next one takes it, so bubbles close up
// and a waiting result does not block intake while earlier stages are free.
// Reset empties every stage.
`default_nettype none
module alpha_unpremultiply_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ap_pkg::ChanW-1:0]  req_blue_in,
   input  wire logic [ap_pkg::ChanW-1:0]  req_green_in,
   input  wire logic [ap_pkg::ChanW-1:0]  req_red_in,
   input  wire logic [ap_pkg::ChanW-1:0]  req_alpha_in,
   input  wire logic                      req_frame_end_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ap_pkg::ChanW-1:0]       rsp_blue_out,
   output logic [ap_pkg::ChanW-1:0]       rsp_green_out,
   output logic [ap_pkg::ChanW-1:0]       rsp_red_out,
   output logic [ap_pkg::ChanW-1:0]       rsp_alpha_out,
   output logic                           rsp_frame_end_out
);
   import ap_pkg::*;

   logic        stg_valid [QuotN+1];
   logic        stg_ready [QuotN+1];
   ap_cell_type stg_data  [QuotN+1];
   logic [ChanW-1:0] color_out [ColorN];

   ap_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .blue       (req_blue_in),
      .green      (req_green_in),
      .red        (req_red_in),
      .alpha      (req_alpha_in),
      .frame_end  (req_frame_end_in),
      .down_valid (stg_valid[0]),
      .down_data  (stg_data[0]),
      .down_ready (stg_ready[0])
   );

   for (genvar k = 0; k < QuotN; k++) begin : g_cell
      ap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stg_valid[k]),
         .up_ready   (stg_ready[k]),
         .up_data    (stg_data[k]),
         .down_valid (stg_valid[k+1]),
         .down_data  (stg_data[k+1]),
         .down_ready (stg_ready[k+1])
      );
   end

   assign stg_ready[QuotN] = rsp_ready;

   always_comb begin
      for (int i = 0; i < ColorN; i++) begin
         if (stg_data[QuotN].alpha == '0) begin
            color_out[i] = '0;
         end else if (stg_data[QuotN].chan[i].ovf) begin
            color_out[i] = ChanMax;
         end else begin
            color_out[i] = stg_data[QuotN].chan[i].quo;
         end
      end
   end

   assign rsp_valid         = stg_valid[QuotN];
   assign rsp_blue_out      = color_out[0];
   assign rsp_green_out     = color_out[1];
   assign rsp_red_out       = color_out[2];
   assign rsp_alpha_out     = stg_data[QuotN].alpha;
   assign rsp_frame_end_out = stg_data[QuotN].frame_end;

endmodule
`default_nettype wire

/* sv/ap_prep.sv */
// Entry stage: forms the rounded dividend of each color and detects quotient overflow.
`default_nettype none
module ap_prep (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      up_valid,
   output logic                           up_ready,
   input  wire logic [ap_pkg::ChanW-1:0]  blue,
   input  wire logic [ap_pkg::ChanW-1:0]  green,
   input  wire logic [ap_pkg::ChanW-1:0]  red,
   input  wire logic [ap_pkg::ChanW-1:0]  alpha,
   input  wire logic                      frame_end,
   output logic                           down_valid,
   output ap_pkg::ap_cell_type            down_data,
   input  wire logic                      down_ready
);
   import ap_pkg::*;

   logic                    valid_ff, valid_in;
   ap_cell_type             data_ff, data_in;
   logic [ChanW-1:0]        color [ColorN];
   logic [2*ChanW-1:0]      dvd   [ColorN];

   assign color[0] = blue;
   assign color[1] = green;
   assign color[2] = red;

   always_comb begin
      data_in.alpha     = alpha;
      data_in.frame_end = frame_end;
      for (int i = 0; i < ColorN; i++) begin
         dvd[i] = {color[i], {ChanW{1'b0}}} - {{ChanW{1'b0}}, color[i]}
                  + {{(ChanW+1){1'b0}}, alpha[ChanW-1:1]};
         data_in.chan[i].rem = dvd[i][2*ChanW-1:ChanW];
         data_in.chan[i].low = dvd[i][ChanW-1:0];
         data_in.chan[i].quo = '0;
         data_in.chan[i].ovf = (dvd[i][2*ChanW-1:ChanW] >= alpha);
      end
   end

   assign up_ready   = ~valid_ff | down_ready;
   assign valid_in   = up_ready ? up_valid : valid_ff;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ap_cell.sv */
// Division cell: develops one quotient bit for each color and hands the item on.
`default_nettype none
module ap_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                up_valid,
   output logic                     up_ready,
   input  wire ap_pkg::ap_cell_type up_data,
   output logic                     down_valid,
   output ap_pkg::ap_cell_type      down_data,
   input  wire logic                down_ready
);
   import ap_pkg::*;

   logic        valid_ff, valid_in;
   ap_cell_type data_ff, data_in;

   always_comb begin
      data_in = up_data;
      for (int i = 0; i < ColorN; i++) begin
         data_in.chan[i] = ap_div_step(up_data.chan[i], up_data.alpha);
      end
   end

   assign up_ready   = ~valid_ff | down_ready;
   assign valid_in   = up_ready ? up_valid : valid_ff;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ap_checker.sv */
// Port checker for the alpha unpremultiply block and its bind to the top level.
`default_nettype none
module ap_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [ap_pkg::ChanW-1:0] rsp_blue_out,
   input wire logic [ap_pkg::ChanW-1:0] rsp_green_out,
   input wire logic [ap_pkg::ChanW-1:0] rsp_red_out,
   input wire logic [ap_pkg::ChanW-1:0] rsp_alpha_out,
   input wire logic                     rsp_frame_end_out
);
   import ap_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_blue_out) && $stable(rsp_green_out)
         && $stable(rsp_red_out) && $stable(rsp_alpha_out) && $stable(rsp_frame_end_out))
      else $error("result item changed while stalled");

   a_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alpha_out == '0 |->
         rsp_blue_out == '0 && rsp_green_out == '0 && rsp_red_out == '0)
      else $error("transparent item has nonzero color");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("intake blocked while output is empty");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind alpha_unpremultiply_top ap_checker u_ap_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_blue_out      (rsp_blue_out),
   .rsp_green_out     (rsp_green_out),
   .rsp_red_out       (rsp_red_out),
   .rsp_alpha_out     (rsp_alpha_out),
   .rsp_frame_end_out (rsp_frame_end_out)
);
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the alpha unpremultiply block: directed table, then random pixels.
`default_nettype none
module tb;

   localparam int unsigned W        = ap_pkg::ChanW;
   localparam int          RANDOM_N = 1830;
   localparam int          HOLD_N   = 60;
   localparam int          TAIL_N   = 24;
   localparam int          LIMIT_N  = 400000;

   typedef struct packed {
      logic [W-1:0] blue;
      logic [W-1:0] green;
      logic [W-1:0] red;
      logic [W-1:0] alpha;
      logic         frame_end;
   } pixel_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic [W-1:0] req_blue_in = '0;
   logic [W-1:0] req_green_in = '0;
   logic [W-1:0] req_red_in = '0;
   logic [W-1:0] req_alpha_in = '0;
   logic         req_frame_end_in = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [W-1:0] rsp_blue_out;
   logic [W-1:0] rsp_green_out;
   logic [W-1:0] rsp_red_out;
   logic [W-1:0] rsp_alpha_out;
   logic         rsp_frame_end_out;

   pixel_type want_q[$];
   pixel_type table_in[$];
   pixel_type table_want[$];
   bit        table_fixed[$];

   int     fail_count = 0;
   int     sent_count = 0;
   int     checked_count = 0;
   int     frame_count = 0;
   int     cycles = 0;
   int     hold_asks = 0;
   int     hold_seen = 0;
   int     hold_left = 0;
   int     gap_left = 0;
   bit     idle_on = 1'b1;

   alpha_unpremultiply_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_blue_in       (req_blue_in),
      .req_green_in      (req_green_in),
      .req_red_in        (req_red_in),
      .req_alpha_in      (req_alpha_in),
      .req_frame_end_in  (req_frame_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_alpha_out     (rsp_alpha_out),
      .rsp_frame_end_out (rsp_frame_end_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_N) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, want_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [W-1:0] straight_color(input logic [W-1:0] c,
                                                   input logic [W-1:0] a);
      logic [31:0] q;
      if (a == '0)
         return '0;
      if (a == ap_pkg::ChanMax)
         return c;
      q = (c * 32'd255 + (a >> 1)) / a;
      if (q > ap_pkg::ChanMax)
         return ap_pkg::ChanMax;
      return q[W-1:0];
   endfunction

   function automatic pixel_type straight_pixel(input pixel_type p);
      pixel_type s;
      s.blue      = straight_color(p.blue, p.alpha);
      s.green     = straight_color(p.green, p.alpha);
      s.red       = straight_color(p.red, p.alpha);
      s.alpha     = p.alpha;
      s.frame_end = p.frame_end;
      return s;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int        kind;
      kind        = $urandom_range(0, 9);
      p.alpha     = W'($urandom);
      p.blue      = W'($urandom);
      p.green     = W'($urandom);
      p.red       = W'($urandom);
      p.frame_end = 1'b0;
      case (kind)
         0: begin
            p.alpha = '0;
         end
         1: begin
            p.alpha = ap_pkg::ChanMax;
         end
         2: begin
            p.alpha = W'($urandom_range(1, 3));
         end
         3, 4: begin
         end
         default: begin
            p.blue  = W'($urandom_range(0, p.alpha));
            p.green = W'($urandom_range(0, p.alpha));
            p.red   = W'($urandom_range(0, p.alpha));
         end
      endcase
      return p;
   endfunction

   task automatic add_row(input int b, input int g, input int r, input int a, input int e,
                          input bit fixed, input int xb, input int xg, input int xr);
      pixel_type p;
      pixel_type x;
      p.blue      = W'(b);
      p.green     = W'(g);
      p.red       = W'(r);
      p.alpha     = W'(a);
      p.frame_end = 1'(e);
      x.blue      = W'(xb);
      x.green     = W'(xg);
      x.red       = W'(xr);
      x.alpha     = W'(a);
      x.frame_end = 1'(e);
      table_in.push_back(p);
      table_want.push_back(x);
      table_fixed.push_back(fixed);
   endtask

   task automatic send_pixel(input pixel_type p, input pixel_type want);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_blue_in      <= p.blue;
      req_green_in     <= p.green;
      req_red_in       <= p.red;
      req_alpha_in     <= p.alpha;
      req_frame_end_in <= p.frame_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want_q.push_back(want);
      sent_count++;
      if (p.frame_end)
         frame_count++;
   endtask

   task automatic check_pixel(input pixel_type got);
      pixel_type want;
      bit        bad;
      checked_count++;
      if (want_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("Result with no item expected: b=%0d g=%0d r=%0d a=%0d e=%0d",
                     got.blue, got.green, got.red, got.alpha, got.frame_end);
         return;
      end
      want = want_q.pop_front();
      bad  = (got.blue !== want.blue) || (got.green !== want.green) ||
             (got.red !== want.red) || (got.alpha !== want.alpha) ||
             (got.frame_end !== want.frame_end);
      if (bad) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"Mismatch on result %0d: expected b=%0d g=%0d r=%0d a=%0d e=%0d,",
                      " got b=%0d g=%0d r=%0d a=%0d e=%0d"},
                     checked_count, want.blue, want.green, want.red, want.alpha,
                     want.frame_end, got.blue, got.green, got.red, got.alpha,
                     got.frame_end);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_pixel({rsp_blue_out, rsp_green_out, rsp_red_out, rsp_alpha_out,
                         rsp_frame_end_out});
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_N;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      pixel_type p;
      int        frame_left;
      add_row(  0,   0,   0,   0, 0, 1,   0,   0,   0);
      add_row(255, 255, 255,   0, 1, 1,   0,   0,   0);
      add_row(255, 255, 255, 255, 1, 1, 255, 255, 255);
      add_row(  0,   0,   0, 255, 0, 1,   0,   0,   0);
      add_row( 18,  52, 200, 255, 0, 1,  18,  52, 200);
      add_row(  1,   0,   1,   1, 0, 1, 255,   0, 255);
      add_row(255, 128,   2,   1, 1, 1, 255, 255, 255);
      add_row(100, 100, 100, 100, 0, 1, 255, 255, 255);
      add_row(200, 201, 250, 199, 0, 1, 255, 255, 255);
      add_row(  0,   0,   0, 128, 0, 1,   0,   0,   0);
      add_row( 64, 128,  32, 128, 1, 1, 128, 255,  64);
      add_row(170,  85, 254, 254, 0, 0,   0,   0,   0);
      add_row(  1,   2,   3,   2, 0, 0,   0,   0,   0);
      add_row(127,  63,  31, 254, 1, 0,   0,   0,   0);
      add_row( 85, 170,  15, 240, 0, 0,   0,   0,   0);
      add_row(170,  85, 240, 254, 0, 0,   0,   0,   0);
      add_row(  1,   1,   1,   3, 0, 0,   0,   0,   0);
      add_row( 37, 129,  77, 130, 1, 0,   0,   0,   0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_in[i])
         send_pixel(table_in[i],
                    table_fixed[i] ? table_want[i] : straight_pixel(table_in[i]));

      frame_left = $urandom_range(1, 40);
      for (int i = 0; i < RANDOM_N; i++) begin
         if (i == 500)
            hold_asks++;
         if (i == 800) begin
            req_valid <= 1'b0;
            while (want_q.size() != 0) @(posedge clock);
         end
         idle_on = (i < 1400) ? ((i / 64) % 3 != 2) : 1'b0;
         if (i >= 500 && i < 600)
            idle_on = 1'b0;
         p = random_pixel();
         p.frame_end = (frame_left == 1);
         frame_left--;
         if (frame_left == 0)
            frame_left = $urandom_range(1, 40);
         send_pixel(p, straight_pixel(p));
      end
      req_valid <= 1'b0;

      while (want_q.size() != 0) @(posedge clock);
      repeat (TAIL_N) @(posedge clock);

      $display("Sent %0d pixels in %0d frames; %0d results checked, %0d failures.",
               sent_count, frame_count, checked_count, fail_count);
      $display({"Covered transparent, opaque, over-alpha and rounded pixels",
                " with stalls on both sides."});
      if (fail_count == 0 && want_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* alpha_unpremultiply_top.f */
sv/ap_pkg.sv
sv/ap_prep.sv
sv/ap_cell.sv
sv/alpha_unpremultiply_top.sv
sv/ap_checker.sv
sim/tb.sv
